// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// clocked check, disabled while reset is asserted
`define AST_CHK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// clocked check, active during reset as well
`define AST_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define AST_CHK(label, clk, rst_n, prop)
`define AST_ALWAYS(label, clk, prop)
`endif

`endif

// ===== rtl/core/calu_pkg.sv =====
// ---------------------------------------------------------------------------
// calu_pkg
// operation codes, flag positions and shared types of the cpu alu
// ---------------------------------------------------------------------------
`default_nettype none

package calu_pkg;

    typedef enum logic [5:0] {
        FN_ADD    = 6'd0,
        FN_ADC    = 6'd1,
        FN_SUB    = 6'd2,
        FN_SBC    = 6'd3,
        FN_AND    = 6'd4,
        FN_XOR    = 6'd5,
        FN_OR     = 6'd6,
        FN_CP     = 6'd7,
        FN_INC    = 6'd8,
        FN_DEC    = 6'd9,
        FN_RLC    = 6'd10,
        FN_RRC    = 6'd11,
        FN_RL     = 6'd12,
        FN_RR     = 6'd13,
        FN_SLA    = 6'd14,
        FN_SRA    = 6'd15,
        FN_SWAP   = 6'd16,
        FN_SRL    = 6'd17,
        FN_BIT    = 6'd18,
        FN_RES    = 6'd19,
        FN_SET    = 6'd20,
        FN_DAA    = 6'd21,
        FN_CPL    = 6'd22,
        FN_CCF    = 6'd23,
        FN_SCF    = 6'd24,
        FN_RLCA   = 6'd25,
        FN_RRCA   = 6'd26,
        FN_RLA    = 6'd27,
        FN_RRA    = 6'd28,
        FN_ADD16  = 6'd29,
        FN_ADDSP  = 6'd30,
        FN_INC16  = 6'd31,
        FN_DEC16  = 6'd32
    } t_func;

    // flag bit positions
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    // decimal adjust constants
    localparam logic [7:0] DAA_LO     = 8'h06;
    localparam logic [7:0] DAA_HI     = 8'h60;
    localparam logic [8:0] DAA_LIMIT  = 9'h09F;
    localparam logic [3:0] BCD_DIGMAX = 4'd9;

    typedef struct packed {
        logic [15:0] result;
        logic [3:0]  flags;
        logic        wr;
    } t_alu_res;

endpackage

`default_nettype wire

// ===== rtl/core/cpu_alu_with_flags.sv =====
// ---------------------------------------------------------------------------
// cpu_alu_with_flags
// 8-bit cpu alu with z/n/h/c flags, registered two-stage datapath
// ---------------------------------------------------------------------------
// One operation is taken per transfer on the input channel and exactly one
// result transfer follows on the output channel, in order. The block takes a
// new operation in every cycle while the output side keeps up: an input
// register feeds the 8-bit and 16-bit operation units, whose selected result
// lands in an output register. With the output side always ready a result
// passes the input register and then the output register, and throughput is
// one operation per cycle; when the output side stalls, the two register
// stages fill and the input channel stops taking items until the output
// register drains. The block holds no state between operations: flags come in
// with each operation and the updated flags go out with its result.
`default_nettype none
`include "assert_macros.svh"

module cpu_alu_with_flags (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // operation channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [5:0]  i_func,
    input  wire logic [15:0] i_opnd_a,
    input  wire logic [15:0] i_opnd_b,
    input  wire logic [2:0]  i_bit_index,
    input  wire logic [3:0]  i_flags_in,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [15:0]      o_result,
    output logic [3:0]       o_flags_out,
    output logic             o_writes_result
);
    import calu_pkg::*;

    // input stage
    logic        r_s1_valid;
    t_func       r_s1_func;
    logic [15:0] r_s1_a;
    logic [15:0] r_s1_b;
    logic [2:0]  r_s1_bidx;
    logic [3:0]  r_s1_flags;

    // output stage
    logic        r_out_valid;
    t_alu_res    r_out;

    logic        s1_load;
    logic        s2_load;
    logic        is16;
    t_alu_res    res8;
    t_alu_res    res16;
    t_alu_res    n_out;

    // output register frees when empty or when its transfer completes;
    // input register frees when empty or when its item moves on
    assign s2_load    = ~r_out_valid | i_out_ready;
    assign o_in_ready = ~r_s1_valid | s2_load;
    assign s1_load    = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_func  <= t_func'(i_func);
            r_s1_a     <= i_opnd_a;
            r_s1_b     <= i_opnd_b;
            r_s1_bidx  <= i_bit_index;
            r_s1_flags <= i_flags_in;
        end
    end

    calu_alu8 u_alu8 (
        .i_func (r_s1_func),
        .i_a    (r_s1_a[7:0]),
        .i_b    (r_s1_b[7:0]),
        .i_bidx (r_s1_bidx),
        .i_fin  (r_s1_flags),
        .o_res  (res8)
    );

    calu_alu16 u_alu16 (
        .i_func (r_s1_func),
        .i_a    (r_s1_a),
        .i_b    (r_s1_b),
        .i_fin  (r_s1_flags),
        .o_res  (res16)
    );

    // 16-bit ops take the wide unit, everything else (unused codes too)
    // comes from the 8-bit unit
    assign is16  = r_s1_func inside {[FN_ADD16:FN_DEC16]};
    assign n_out = is16 ? res16 : res8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result        = r_out.result;
    assign o_flags_out     = r_out.flags;
    assign o_writes_result = r_out.wr;

    // an item in the input stage reaches the output register when it frees
    `AST_CHK(a_s1_moves, i_clk, i_rst_n, (r_s1_valid && s2_load) |=> r_out_valid)
    // a blocked input stage keeps its item
    `AST_CHK(a_s1_holds, i_clk, i_rst_n, (r_s1_valid && !s2_load) |=> (r_s1_valid && $stable(r_s1_a) && $stable(r_s1_func)))
    // 8-bit ops never set the upper result byte
    `AST_CHK(a_upper_zero, i_clk, i_rst_n, (r_s1_valid && s2_load && !is16) |=> (o_result[15:8] == 8'h00))
    // non-writing results carry only a low byte
    `AST_CHK(a_nowr_low, i_clk, i_rst_n, (o_out_valid && !o_writes_result) |-> (o_result[15:8] == 8'h00))
    // both stages empty right after reset
    `AST_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> (!r_s1_valid && !r_out_valid))

endmodule

`default_nettype wire

// ===== rtl/core/calu_alu8.sv =====
// ---------------------------------------------------------------------------
// calu_alu8
// 8-bit arithmetic, logic, rotate, bit and flag operations
// ---------------------------------------------------------------------------
`default_nettype none

module calu_alu8 (
    input  var calu_pkg::t_func    i_func,
    input  wire logic [7:0]        i_a,
    input  wire logic [7:0]        i_b,
    input  wire logic [2:0]        i_bidx,
    input  wire logic [3:0]        i_fin,
    output calu_pkg::t_alu_res     o_res
);
    import calu_pkg::*;

    logic       cin;
    logic [8:0] add_sum;
    logic [8:0] sub_diff;
    logic [8:0] incdec;
    logic [7:0] bit_mask;
    logic       daa_lo_adj;
    logic [8:0] daa_t1;
    logic       daa_hi_adj;
    logic [8:0] daa_add;
    logic [7:0] daa_s1;
    logic [7:0] daa_sub;
    logic [7:0] daa_r;
    logic       daa_c;
    logic [7:0] r8;

    function automatic logic [3:0] f_znhc(logic [7:0] r, logic n, logic h, logic c);
        return {(r == 8'h00), n, h, c};
    endfunction

    assign cin = i_fin[FLAG_C];

    assign add_sum  = {1'b0, i_a} + {1'b0, i_b}
                    + {8'h00, (i_func == FN_ADC) & cin};
    assign sub_diff = {1'b0, i_a} - {1'b0, i_b}
                    - {8'h00, (i_func == FN_SBC) & cin};
    assign incdec   = (i_func == FN_INC) ? ({1'b0, i_a} + 9'd1) : ({1'b0, i_a} - 9'd1);
    assign bit_mask = 8'h01 << i_bidx;

    // decimal adjust, add path
    assign daa_lo_adj = i_fin[FLAG_H] | (i_a[3:0] > BCD_DIGMAX);
    assign daa_t1     = {1'b0, i_a} + (daa_lo_adj ? {1'b0, DAA_LO} : 9'h000);
    assign daa_hi_adj = cin | (daa_t1 > DAA_LIMIT);
    assign daa_add    = daa_t1 + (daa_hi_adj ? {1'b0, DAA_HI} : 9'h000);
    // decimal adjust, subtract path
    assign daa_s1     = i_fin[FLAG_H] ? (i_a - DAA_LO) : i_a;
    assign daa_sub    = cin ? (daa_s1 - DAA_HI) : daa_s1;
    assign daa_r      = i_fin[FLAG_N] ? daa_sub : daa_add[7:0];
    assign daa_c      = cin | (~i_fin[FLAG_N] & daa_add[8]);

    always_comb begin
        r8           = i_a;
        o_res.flags  = i_fin;
        o_res.wr     = 1'b1;
        case (i_func)
            FN_ADD, FN_ADC: begin
                r8          = add_sum[7:0];
                o_res.flags = f_znhc(r8, 1'b0, i_a[4] ^ i_b[4] ^ add_sum[4], add_sum[8]);
            end
            FN_SUB, FN_SBC, FN_CP: begin
                o_res.flags = f_znhc(sub_diff[7:0], 1'b1,
                                     i_a[4] ^ i_b[4] ^ sub_diff[4], sub_diff[8]);
                if (i_func == FN_CP) begin
                    o_res.wr = 1'b0;
                end else begin
                    r8 = sub_diff[7:0];
                end
            end
            FN_AND: begin
                r8          = i_a & i_b;
                o_res.flags = f_znhc(r8, 1'b0, 1'b1, 1'b0);
            end
            FN_XOR: begin
                r8          = i_a ^ i_b;
                o_res.flags = f_znhc(r8, 1'b0, 1'b0, 1'b0);
            end
            FN_OR: begin
                r8          = i_a | i_b;
                o_res.flags = f_znhc(r8, 1'b0, 1'b0, 1'b0);
            end
            FN_INC, FN_DEC: begin
                r8          = incdec[7:0];
                o_res.flags = f_znhc(r8, i_func == FN_DEC, i_a[4] ^ incdec[4], cin);
            end
            FN_RLC: begin
                r8          = {i_a[6:0], i_a[7]};
                o_res.flags = f_znhc(r8, 1'b0, 1'b0, i_a[7]);
            end
            FN_RRC: begin
                r8          = {i_a[0], i_a[7:1]};
                o_res.flags = f_znhc(r8, 1'b0, 1'b0, i_a[0]);
            end
            FN_RL: begin
                r8          = {i_a[6:0], cin};
                o_res.flags = f_znhc(r8, 1'b0, 1'b0, i_a[7]);
            end
            FN_RR: begin
                r8          = {cin, i_a[7:1]};
                o_res.flags = f_znhc(r8, 1'b0, 1'b0, i_a[0]);
            end
            FN_SLA: begin
                r8          = {i_a[6:0], 1'b0};
                o_res.flags = f_znhc(r8, 1'b0, 1'b0, i_a[7]);
            end
            FN_SRA: begin
                r8          = {i_a[7], i_a[7:1]};
                o_res.flags = f_znhc(r8, 1'b0, 1'b0, i_a[0]);
            end
            FN_SWAP: begin
                r8          = {i_a[3:0], i_a[7:4]};
                o_res.flags = f_znhc(r8, 1'b0, 1'b0, 1'b0);
            end
            FN_SRL: begin
                r8          = {1'b0, i_a[7:1]};
                o_res.flags = f_znhc(r8, 1'b0, 1'b0, i_a[0]);
            end
            FN_BIT: begin
                o_res.flags = {~|(i_a & bit_mask), 1'b0, 1'b1, cin};
                o_res.wr    = 1'b0;
            end
            FN_RES: r8 = i_a & ~bit_mask;
            FN_SET: r8 = i_a | bit_mask;
            FN_DAA: begin
                r8          = daa_r;
                o_res.flags = {(daa_r == 8'h00), i_fin[FLAG_N], 1'b0, daa_c};
            end
            FN_CPL: begin
                r8          = ~i_a;
                o_res.flags = i_fin | 4'b0110;
            end
            FN_CCF: begin
                o_res.flags = {i_fin[FLAG_Z], 2'b00, ~cin};
                o_res.wr    = 1'b0;
            end
            FN_SCF: begin
                o_res.flags = {i_fin[FLAG_Z], 2'b00, 1'b1};
                o_res.wr    = 1'b0;
            end
            FN_RLCA: begin
                r8          = {i_a[6:0], i_a[7]};
                o_res.flags = {3'b000, i_a[7]};
            end
            FN_RRCA: begin
                r8          = {i_a[0], i_a[7:1]};
                o_res.flags = {3'b000, i_a[0]};
            end
            FN_RLA: begin
                r8          = {i_a[6:0], cin};
                o_res.flags = {3'b000, i_a[7]};
            end
            FN_RRA: begin
                r8          = {cin, i_a[7:1]};
                o_res.flags = {3'b000, i_a[0]};
            end
            default: begin
                // unused codes and 16-bit ops
                r8       = 8'h00;
                o_res.wr = 1'b0;
            end
        endcase
        o_res.result = {8'h00, r8};
    end

endmodule

`default_nettype wire

// ===== rtl/core/calu_alu16.sv =====
// ---------------------------------------------------------------------------
// calu_alu16
// 16-bit add to hl, sp plus signed byte, increment and decrement
// ---------------------------------------------------------------------------
`default_nettype none

module calu_alu16 (
    input  var calu_pkg::t_func    i_func,
    input  wire logic [15:0]       i_a,
    input  wire logic [15:0]       i_b,
    input  wire logic [3:0]        i_fin,
    output calu_pkg::t_alu_res     o_res
);
    import calu_pkg::*;

    logic [16:0] sum16;
    logic [15:0] sext_b;
    logic [15:0] sum_sp;

    assign sum16  = {1'b0, i_a} + {1'b0, i_b};
    assign sext_b = {{8{i_b[7]}}, i_b[7:0]};
    assign sum_sp = i_a + sext_b;

    always_comb begin
        o_res.result = 16'h0000;
        o_res.flags  = i_fin;
        o_res.wr     = 1'b1;
        case (i_func)
            FN_ADD16: begin
                o_res.result = sum16[15:0];
                o_res.flags  = {i_fin[FLAG_Z], 1'b0, i_a[12] ^ i_b[12] ^ sum16[12], sum16[16]};
            end
            FN_ADDSP: begin
                // half and full carry come from the low byte
                o_res.result = sum_sp;
                o_res.flags  = {2'b00, i_a[4] ^ sext_b[4] ^ sum_sp[4],
                                i_a[8] ^ sext_b[8] ^ sum_sp[8]};
            end
            FN_INC16: o_res.result = i_a + 16'd1;
            FN_DEC16: o_res.result = i_a - 16'd1;
            default:  o_res.wr = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ===== tb/cpu_alu_with_flags_tb.sv =====
// ---------------------------------------------------------------------------
// cpu_alu_with_flags_tb
// self-checking bench for the cpu alu: every operation transfer is predicted
// in a scoreboard and each result transfer is checked in order, under bursty
// operation traffic and a result side that stalls on its own pattern
// ---------------------------------------------------------------------------
module cpu_alu_with_flags_tb;

    import calu_pkg::*;

    // cycles without any transfer before the run is declared hung
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned RANDOM_OPS  = 1100;
    // codes past the last operation, expected to do nothing
    localparam logic [5:0]  FN_UNUSED_LO = 6'd33;
    localparam logic [5:0]  FN_UNUSED_HI = 6'd63;

    localparam logic [15:0] CORNER_WORDS [8] = '{
        16'h0000, 16'hFFFF, 16'h00FF, 16'h0080,
        16'h7FFF, 16'h8000, 16'h0FFF, 16'h000F
    };

    // result side stall patterns
    typedef enum int unsigned {
        RX_OPEN,
        RX_COIN,
        RX_THROTTLE,
        RX_SPARSE
    } t_rx_pattern;

    // -----------------------------------------------------------------------
    // scoreboard: alu prediction and in-order result check
    // -----------------------------------------------------------------------
    class t_alu_scoreboard;
        t_alu_res    results_due[$];
        int unsigned errors;

        function automatic logic [3:0] pack_flags(logic z, logic n, logic h, logic c);
            logic [3:0] f;
            f[FLAG_Z] = z;
            f[FLAG_N] = n;
            f[FLAG_H] = h;
            f[FLAG_C] = c;
            return f;
        endfunction

        // 8-bit result with zero flag taken from the byte
        function automatic t_alu_res byte_op(logic [7:0] r8, logic n, logic h, logic c);
            t_alu_res e;
            e.result = {8'h00, r8};
            e.flags  = pack_flags(r8 == 8'h00, n, h, c);
            e.wr     = 1'b1;
            return e;
        endfunction

        function automatic t_alu_res alu_compute(logic [5:0] fn, logic [15:0] a16,
                                                 logic [15:0] b16, logic [2:0] idx,
                                                 logic [3:0] fin);
            logic [7:0]  a;
            logic [7:0]  b;
            logic [16:0] t;
            logic [16:0] cb;
            logic [15:0] m;
            logic        c;
            t_alu_res    e;
            a = a16[7:0];
            b = b16[7:0];
            c = fin[FLAG_C];
            // non-writing ops other than unused codes keep the low byte of the first operand
            e.result = {8'h00, a};
            e.flags  = fin;
            e.wr     = 1'b1;
            case (fn)
                FN_ADD, FN_ADC: begin
                    t  = {9'd0, a} + {9'd0, b} + {16'd0, (fn == FN_ADC) & c};
                    cb = {9'd0, a} ^ {9'd0, b} ^ t;
                    e  = byte_op(t[7:0], 1'b0, cb[4], cb[8]);
                end
                FN_SUB, FN_SBC, FN_CP: begin
                    t  = {9'd0, a} - {9'd0, b} - {16'd0, (fn == FN_SBC) & c};
                    cb = {9'd0, a} ^ {9'd0, b} ^ t;
                    e.flags = pack_flags(t[7:0] == 8'h00, 1'b1, cb[4], cb[8]);
                    if (fn == FN_CP) begin
                        e.wr = 1'b0;
                    end else begin
                        e.result = {8'h00, t[7:0]};
                    end
                end
                FN_AND:  e = byte_op(a & b, 1'b0, 1'b1, 1'b0);
                FN_XOR:  e = byte_op(a ^ b, 1'b0, 1'b0, 1'b0);
                FN_OR:   e = byte_op(a | b, 1'b0, 1'b0, 1'b0);
                FN_INC, FN_DEC: begin
                    // carry is left alone
                    t  = (fn == FN_INC) ? {9'd0, a} + 17'd1 : {9'd0, a} - 17'd1;
                    cb = {9'd0, a} ^ 17'd1 ^ t;
                    e  = byte_op(t[7:0], fn == FN_DEC, cb[4], c);
                end
                FN_RLC:  e = byte_op({a[6:0], a[7]}, 1'b0, 1'b0, a[7]);
                FN_RRC:  e = byte_op({a[0], a[7:1]}, 1'b0, 1'b0, a[0]);
                FN_RL:   e = byte_op({a[6:0], c}, 1'b0, 1'b0, a[7]);
                FN_RR:   e = byte_op({c, a[7:1]}, 1'b0, 1'b0, a[0]);
                FN_SLA:  e = byte_op({a[6:0], 1'b0}, 1'b0, 1'b0, a[7]);
                FN_SRA:  e = byte_op({a[7], a[7:1]}, 1'b0, 1'b0, a[0]);
                FN_SWAP: e = byte_op({a[3:0], a[7:4]}, 1'b0, 1'b0, 1'b0);
                FN_SRL:  e = byte_op({1'b0, a[7:1]}, 1'b0, 1'b0, a[0]);
                FN_BIT: begin
                    e.flags = pack_flags(!a[idx], 1'b0, 1'b1, c);
                    e.wr    = 1'b0;
                end
                FN_RES:  e.result = {8'h00, a & ~(8'h01 << idx)};
                FN_SET:  e.result = {8'h00, a | (8'h01 << idx)};
                FN_DAA: begin
                    t = {9'd0, a};
                    if (!fin[FLAG_N]) begin
                        if (fin[FLAG_H] || t[3:0] > BCD_DIGMAX) t = t + DAA_LO;
                        if (c || t > DAA_LIMIT) t = t + DAA_HI;
                    end else begin
                        if (fin[FLAG_H]) t = {9'd0, t[7:0] - DAA_LO};
                        if (c) t = {9'd0, t[7:0] - DAA_HI};
                    end
                    e.result = {8'h00, t[7:0]};
                    e.flags  = pack_flags(t[7:0] == 8'h00, fin[FLAG_N], 1'b0, c | t[8]);
                end
                FN_CPL: begin
                    e.result        = {8'h00, ~a};
                    e.flags[FLAG_N] = 1'b1;
                    e.flags[FLAG_H] = 1'b1;
                end
                FN_CCF: begin
                    e.flags = pack_flags(fin[FLAG_Z], 1'b0, 1'b0, !c);
                    e.wr    = 1'b0;
                end
                FN_SCF: begin
                    e.flags = pack_flags(fin[FLAG_Z], 1'b0, 1'b0, 1'b1);
                    e.wr    = 1'b0;
                end
                // accumulator rotates clear zero as well
                FN_RLCA: begin
                    e.result = {8'h00, a[6:0], a[7]};
                    e.flags  = pack_flags(1'b0, 1'b0, 1'b0, a[7]);
                end
                FN_RRCA: begin
                    e.result = {8'h00, a[0], a[7:1]};
                    e.flags  = pack_flags(1'b0, 1'b0, 1'b0, a[0]);
                end
                FN_RLA: begin
                    e.result = {8'h00, a[6:0], c};
                    e.flags  = pack_flags(1'b0, 1'b0, 1'b0, a[7]);
                end
                FN_RRA: begin
                    e.result = {8'h00, c, a[7:1]};
                    e.flags  = pack_flags(1'b0, 1'b0, 1'b0, a[0]);
                end
                FN_ADD16: begin
                    t  = {1'b0, a16} + {1'b0, b16};
                    cb = {1'b0, a16} ^ {1'b0, b16} ^ t;
                    e.result = t[15:0];
                    e.flags  = pack_flags(fin[FLAG_Z], 1'b0, cb[12], cb[16]);
                end
                FN_ADDSP: begin
                    // flags come from the low byte addition
                    m  = {{8{b[7]}}, b};
                    t  = {1'b0, a16} + {1'b0, m};
                    cb = {1'b0, a16} ^ {1'b0, m} ^ t;
                    e.result = t[15:0];
                    e.flags  = pack_flags(1'b0, 1'b0, cb[4], cb[8]);
                end
                FN_INC16: e.result = a16 + 16'd1;
                FN_DEC16: e.result = a16 - 16'd1;
                default: begin
                    e.result = 16'h0000;
                    e.wr     = 1'b0;
                end
            endcase
            return e;
        endfunction

        function void note_op(logic [5:0] fn, logic [15:0] a16, logic [15:0] b16,
                              logic [2:0] idx, logic [3:0] fin);
            results_due.push_back(alu_compute(fn, a16, b16, idx, fin));
        endfunction

        function int unsigned pending();
            return results_due.size();
        endfunction

        function void check_result(logic [15:0] res, logic [3:0] flags, logic wr);
            t_alu_res e;
            if (results_due.size() == 0) begin
                errors++;
                $display("%0t: result transfer with none expected, got %h %h %b",
                         $time, res, flags, wr);
                return;
            end
            e = results_due.pop_front();
            if (res !== e.result) begin
                errors++;
                $display("%0t: result mismatch, expected %h, got %h", $time, e.result, res);
            end
            if (flags !== e.flags) begin
                errors++;
                $display("%0t: flags mismatch, expected %b, got %b", $time, e.flags, flags);
            end
            if (wr !== e.wr) begin
                errors++;
                $display("%0t: write-back mismatch, expected %b, got %b", $time, e.wr, wr);
            end
        endfunction

        function void report_leftovers();
            if (results_due.size() != 0) begin
                errors += results_due.size();
                $display("%0t: %0d results never arrived", $time, results_due.size());
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // signals, all inputs known from time zero
    // -----------------------------------------------------------------------
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic [5:0]  i_func          = '0;
    logic [15:0] i_opnd_a        = '0;
    logic [15:0] i_opnd_b        = '0;
    logic [2:0]  i_bit_index     = '0;
    logic [3:0]  i_flags_in      = '0;
    logic        i_out_ready     = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [15:0] o_result;
    logic [3:0]  o_flags_out;
    logic        o_writes_result;

    t_alu_scoreboard sb = new();

    int unsigned ops_sent;
    int unsigned idle_cycles;
    t_rx_pattern rx_mode  = RX_OPEN;
    int unsigned rx_left;
    int unsigned rx_phase;

    cpu_alu_with_flags uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_opnd_a        (i_opnd_a),
        .i_opnd_b        (i_opnd_b),
        .i_bit_index     (i_bit_index),
        .i_flags_in      (i_flags_in),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result        (o_result),
        .o_flags_out     (o_flags_out),
        .o_writes_result (o_writes_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // monitor: both channels sampled at the edge, plus the hang watchdog
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // an accepted operation is predicted right away
            if (i_in_valid && o_in_ready) begin
                sb.note_op(i_func, i_opnd_a, i_opnd_b, i_bit_index, i_flags_in);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_result, o_flags_out, o_writes_result);
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // result side: ready follows a randomly drawn pattern that runs for a random span of cycles
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_pattern'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 200);
        end else begin
            rx_left--;
        end
        rx_phase++;
        case (rx_mode)
            RX_OPEN:     i_out_ready <= 1'b1;
            RX_COIN:     i_out_ready <= 1'($urandom_range(0, 1));
            // ready is low whenever the phase count is a multiple of four, so both register stages can fill
            RX_THROTTLE: i_out_ready <= (rx_phase % 4) != 0;
            default:     i_out_ready <= $urandom_range(0, 4) == 0;
        endcase
    end

    // -----------------------------------------------------------------------
    // sender tasks, each called at a rising edge
    // -----------------------------------------------------------------------
    task automatic send_op(logic [5:0] fn, logic [15:0] a16, logic [15:0] b16,
                           logic [2:0] idx, logic [3:0] fin);
        i_in_valid  <= 1'b1;
        i_func      <= fn;
        i_opnd_a    <= a16;
        i_opnd_b    <= b16;
        i_bit_index <= idx;
        i_flags_in  <= fin;
        // hold until the transfer happens
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        ops_sent++;
    endtask

    task automatic pause_sender(int unsigned cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // stop sending until every predicted result has been checked
    task automatic wait_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic logic [15:0] pick_word();
        if ($urandom_range(0, 5) == 0) return CORNER_WORDS[3'($urandom_range(0, 7))];
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] pick_bcd();
        return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    endfunction

    task automatic send_random_op();
        logic [5:0] fn;
        logic [7:0] x;
        logic [7:0] y;
        logic [3:0] fin;
        t_alu_res   sum;
        x   = pick_bcd();
        y   = pick_bcd();
        fin = 4'($urandom);
        if ($urandom_range(0, 11) == 0) begin
            // bcd add or subtract followed by its decimal adjust, as code issues it
            fn  = 6'($urandom_range(FN_ADD, FN_SBC));
            sum = sb.alu_compute(fn, {8'h00, x}, {8'h00, y}, 3'd0, fin);
            send_op(fn, {8'h00, x}, {8'h00, y}, 3'($urandom), fin);
            send_op(FN_DAA, sum.result, pick_word(), 3'($urandom), sum.flags);
        end else begin
            // a few unused codes mixed in
            if ($urandom_range(0, 19) == 0) begin
                fn = 6'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
            end else begin
                fn = 6'($urandom_range(FN_ADD, FN_DEC16));
            end
            send_op(fn, pick_word(), pick_word(), 3'($urandom), fin);
        end
    endtask

    // -----------------------------------------------------------------------
    // stimulus
    // -----------------------------------------------------------------------
    initial begin
        int unsigned target;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: flag extremes and every operation, flags packed as znhc
        send_op(FN_ADD,   16'h00FF, 16'h0001, 3'd0, 4'b0000);
        send_op(FN_ADD,   16'hFF08, 16'hFF08, 3'd0, 4'b1111);
        send_op(FN_ADC,   16'h00FF, 16'h0000, 3'd0, 4'b0001);
        send_op(FN_SUB,   16'h0000, 16'h0001, 3'd0, 4'b0000);
        send_op(FN_SBC,   16'h0010, 16'h000F, 3'd0, 4'b0001);
        send_op(FN_CP,    16'h0042, 16'h0042, 3'd0, 4'b0000);
        send_op(FN_AND,   16'h00FF, 16'h0000, 3'd0, 4'b0101);
        send_op(FN_XOR,   16'h005A, 16'h005A, 3'd0, 4'b0111);
        send_op(FN_OR,    16'h0000, 16'h0000, 3'd0, 4'b1111);
        send_op(FN_INC,   16'h00FF, 16'h0000, 3'd0, 4'b0001);
        send_op(FN_DEC,   16'h0010, 16'h0000, 3'd0, 4'b0000);
        send_op(FN_DEC,   16'h0001, 16'h0000, 3'd0, 4'b0001);
        send_op(FN_RLC,   16'h0080, 16'h0000, 3'd0, 4'b0000);
        send_op(FN_RRC,   16'h0001, 16'h0000, 3'd0, 4'b0000);
        send_op(FN_RL,    16'h0080, 16'h0000, 3'd0, 4'b0001);
        send_op(FN_RR,    16'h0001, 16'h0000, 3'd0, 4'b0000);
        send_op(FN_SLA,   16'h0080, 16'h0000, 3'd0, 4'b0000);
        send_op(FN_SRA,   16'h0081, 16'h0000, 3'd0, 4'b0000);
        send_op(FN_SWAP,  16'h00F0, 16'h0000, 3'd0, 4'b0000);
        send_op(FN_SRL,   16'h0001, 16'h0000, 3'd0, 4'b0000);
        send_op(FN_BIT,   16'h007F, 16'h0000, 3'd7, 4'b0001);
        send_op(FN_BIT,   16'h0001, 16'h0000, 3'd0, 4'b0000);
        send_op(FN_RES,   16'h00FF, 16'h0000, 3'd7, 4'b1010);
        send_op(FN_SET,   16'h0000, 16'h0000, 3'd0, 4'b0000);
        // decimal adjust: carry out of the correction, and the subtract side
        send_op(FN_DAA,   16'h009A, 16'h0000, 3'd0, 4'b0000);
        send_op(FN_DAA,   16'h0000, 16'h0000, 3'd0, 4'b0111);
        send_op(FN_CPL,   16'h0055, 16'h0000, 3'd0, 4'b1001);
        send_op(FN_CCF,   16'h0012, 16'h0000, 3'd0, 4'b1111);
        send_op(FN_SCF,   16'h0034, 16'h0000, 3'd0, 4'b0110);
        send_op(FN_RLCA,  16'h0080, 16'h0000, 3'd0, 4'b1000);
        send_op(FN_RRCA,  16'h0001, 16'h0000, 3'd0, 4'b1000);
        send_op(FN_RLA,   16'h0000, 16'h0000, 3'd0, 4'b1001);
        send_op(FN_RRA,   16'h0001, 16'h0000, 3'd0, 4'b0000);
        // 16-bit add keeps zero; carries out of bits 11 and 15
        send_op(FN_ADD16, 16'hFFFF, 16'h0001, 3'd0, 4'b1000);
        send_op(FN_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'b0111);
        // sp plus signed byte, only the low byte of opnd_b counts
        send_op(FN_ADDSP, 16'hFFFF, 16'h00FF, 3'd0, 4'b1111);
        send_op(FN_ADDSP, 16'h0000, 16'h0080, 3'd0, 4'b0000);
        send_op(FN_ADDSP, 16'h1234, 16'hFF7F, 3'd0, 4'b0000);
        send_op(FN_INC16, 16'hFFFF, 16'h0000, 3'd0, 4'b1111);
        send_op(FN_DEC16, 16'h0000, 16'h0000, 3'd0, 4'b0000);
        send_op(FN_UNUSED_LO, 16'hFFFF, 16'hFFFF, 3'd7, 4'b1010);
        send_op(FN_UNUSED_HI, 16'h1234, 16'h5678, 3'd3, 4'b0101);
        wait_until_drained();

        // random: bursts of transfers separated by short gaps, back-to-back
        // bursts, and now and then a full drain of the pipeline
        target = ops_sent + RANDOM_OPS;
        while (ops_sent < target) begin
            repeat ($urandom_range(1, 48)) send_random_op();
            case ($urandom_range(0, 15))
                0:          wait_until_drained();
                1, 2, 3, 4: ;
                default:    pause_sender($urandom_range(1, 8));
            endcase
        end

        wait_until_drained();
        // keep the clock running to catch any stray result transfer
        repeat (10) @(posedge i_clk);
        sb.report_leftovers();
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
